### sv/sdfsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdfsu_pkg
// Shared types and constants for the smooth-union scene distance evaluator.
// ----------------------------------------------------------------------------
package sdfsu_pkg;

  localparam int MAX_OBJECTS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = $clog2(MAX_OBJECTS);
  localparam int VAL_W       = 40;

  localparam logic [FRAC_BITS:0] ONE_FX  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_FX = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_EVAL    = 1'b1;
  localparam logic KIND_SPHERE  = 1'b0;
  localparam logic KIND_BOX     = 1'b1;
  localparam logic CFG_OBJ_CNT  = 1'b0;
  localparam logic CFG_BLEND_K  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] ext;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DIFF,
    S_SQ,
    S_ROOT,
    S_OBJ,
    S_CMP,
    S_DIV,
    S_H,
    S_MULM,
    S_MULT,
    S_MULK,
    S_NEXT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/sdfsu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdfsu_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module sdfsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/sdf_scene_smooth_union.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_scene_smooth_union
// Smooth-union signed distance of a table of spheres and boxes at a point.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall) carries one word per item. A word
// with func clear writes one object entry and gives no result. A word with
// func set evaluates the scene at the given point and gives exactly one
// distance word on the output channel (out_valid, out_stall). Configuration
// is written through cfg_we, cfg_index and cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// An evaluation visits the objects one at a time. Each object passes through
// the fetch, three squares on one multiplier, a 33-step square root and the
// step to the next entry. Every object after the first adds a compare, and
// where it lies within the blend width the smooth minimum, which begins with
// the bit-serial division. The block takes no new word while an evaluation
// runs. A write may be taken while a result waits at the output; an
// evaluation waits at its end until the output register is free. Reset
// clears control state and sets the object count to one and the blend width
// to 0.1; the object table is undefined.
// ----------------------------------------------------------------------------
module sdf_scene_smooth_union (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [30:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           func,
  input  wire logic [sdfsu_pkg::IDX_W-1:0]    entry_index,
  input  wire logic                           entry_kind,
  input  wire logic signed [31:0]             coord_x,
  input  wire logic signed [31:0]             coord_y,
  input  wire logic signed [31:0]             coord_z,
  input  wire logic [30:0]                    extent,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [31:0]                  distance
);

  import sdfsu_pkg::*;

  state_t state, state_next;

  logic [4:0]  object_count;
  logic [30:0] blend_k;

  logic              ram_we;
  entry_t            wr_entry;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t            rd_entry;

  logic [IDX_W-1:0] obj_idx;
  logic [IDX_W-1:0] last_idx;
  logic [31:0] px, py, pz;
  logic [30:0] kq;

  logic [32:0]        v0, v1, v2;
  logic signed [33:0] box_adj;
  logic [65:0]        sum;
  logic [5:0]         cnt;
  logic [65:0]        rad;
  logic [35:0]        rem;
  logic [32:0]        root;

  logic signed [VAL_W-1:0] acc;
  logic signed [VAL_W-1:0] bval;
  logic signed [VAL_W-1:0] mval;
  logic                    diff_neg;
  logic [31:0]             drem;
  logic [FRAC_BITS-1:0]    quo;
  logic [FRAC_BITS:0]      hval;
  logic [FRAC_BITS:0]      tval;

  logic in_accept;
  logic out_take;
  logic out_free;

  function automatic logic [32:0] axis_mag(input logic [31:0] p, input logic [31:0] c);
    logic signed [32:0] d;
    d = $signed({p[31], p}) - $signed({c[31], c});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic [32:0]        mgx, mgy, mgz;
  logic signed [33:0] qx, qy, qz, qmax;
  logic [32:0]        sq_op;
  logic [65:0]        sq_prod;
  logic [35:0]        root_trial;
  logic [35:0]        root_shift;
  logic signed [VAL_W:0] diff;
  logic signed [VAL_W:0] kext;
  logic [31:0]        drem2;
  logic signed [32:0] amb;
  logic signed [51:0] prod_m;
  logic [33:0]        prod_t;
  logic [47:0]        prod_k;
  logic [IDX_W:0]     n_clamp;

  assign rd_entry  = entry_t'(rd_raw);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;

  assign wr_entry.kind = entry_kind;
  assign wr_entry.cx   = coord_x;
  assign wr_entry.cy   = coord_y;
  assign wr_entry.cz   = coord_z;
  assign wr_entry.ext  = extent;

  sdfsu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_OBJECTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_index),
    .wdata (wr_entry),
    .raddr (obj_idx),
    .rdata (rd_raw)
  );

  always_comb begin
    mgx  = axis_mag(px, rd_entry.cx);
    mgy  = axis_mag(py, rd_entry.cy);
    mgz  = axis_mag(pz, rd_entry.cz);
    qx   = $signed({1'b0, mgx}) - $signed({3'b000, rd_entry.ext});
    qy   = $signed({1'b0, mgy}) - $signed({3'b000, rd_entry.ext});
    qz   = $signed({1'b0, mgz}) - $signed({3'b000, rd_entry.ext});
    qmax = (qx > qy) ? qx : qy;
    qmax = (qmax > qz) ? qmax : qz;
    case (cnt[1:0])
      2'd0:    sq_op = v0;
      2'd1:    sq_op = v1;
      default: sq_op = v2;
    endcase
    sq_prod    = sq_op * sq_op;
    root_shift = {rem[33:0], rad[65:64]};
    root_trial = root_shift - {1'b0, root, 2'b01};
    diff       = $signed({bval[VAL_W-1], bval}) - $signed({acc[VAL_W-1], acc});
    kext       = $signed({{(VAL_W - 30){1'b0}}, blend_k});
    drem2      = {drem[30:0], 1'b0};
    amb        = 33'(acc - bval);
    prod_m     = amb * $signed({1'b0, hval});
    prod_t     = hval * (ONE_FX - hval);
    prod_k     = kq * tval;
    if (object_count == 5'd0) begin
      n_clamp = (IDX_W + 1)'(1);
    end else if (object_count > 5'(MAX_OBJECTS)) begin
      n_clamp = (IDX_W + 1)'(MAX_OBJECTS);
    end else begin
      n_clamp = (IDX_W + 1)'(object_count);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && func == FUNC_EVAL) state_next = S_FETCH;
      S_FETCH: state_next = S_DIFF;
      S_DIFF:  state_next = S_SQ;
      S_SQ:    if (cnt == 6'd2) state_next = S_ROOT;
      S_ROOT:  if (cnt == 6'd32) state_next = S_OBJ;
      S_OBJ:   state_next = (obj_idx == '0) ? S_NEXT : S_CMP;
      S_CMP: begin
        if (diff >= kext || diff <= -kext) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV:   if (cnt == 6'(FRAC_BITS - 2)) state_next = S_H;
      S_H:     state_next = S_MULM;
      S_MULM:  state_next = S_MULT;
      S_MULT:  state_next = S_MULK;
      S_MULK:  state_next = S_NEXT;
      S_NEXT:  state_next = (obj_idx == last_idx) ? S_DONE : S_FETCH;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    ram_we   = (state == S_IDLE) && in_valid && (func == FUNC_WRITE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      object_count <= 5'd1;
      blend_k      <= 31'd6554;
      out_valid    <= 1'b0;
      obj_idx      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_OBJ_CNT) begin
          object_count <= cfg_data[4:0];
        end else begin
          blend_k <= cfg_data;
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (in_accept && func == FUNC_EVAL) begin
        obj_idx <= '0;
      end else if (state == S_NEXT && obj_idx != last_idx) begin
        obj_idx <= obj_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        px       <= coord_x;
        py       <= coord_y;
        pz       <= coord_z;
        kq       <= blend_k;
        last_idx <= IDX_W'(n_clamp - 1'b1);
      end
      S_DIFF: begin
        cnt <= '0;
        sum <= '0;
        if (rd_entry.kind == KIND_SPHERE) begin
          v0      <= mgx;
          v1      <= mgy;
          v2      <= mgz;
          box_adj <= -$signed({3'b000, rd_entry.ext});
        end else begin
          v0      <= qx[33] ? '0 : qx[32:0];
          v1      <= qy[33] ? '0 : qy[32:0];
          v2      <= qz[33] ? '0 : qz[32:0];
          box_adj <= qmax[33] ? qmax : '0;
        end
      end
      S_SQ: begin
        sum <= sum + sq_prod;
        if (cnt == 6'd2) begin
          cnt  <= '0;
          rad  <= sum + sq_prod;
          rem  <= '0;
          root <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      S_ROOT: begin
        cnt <= cnt + 1'b1;
        rad <= {rad[63:0], 2'b00};
        if (!root_trial[35]) begin
          rem  <= root_trial;
          root <= {root[31:0], 1'b1};
        end else begin
          rem  <= root_shift;
          root <= {root[31:0], 1'b0};
        end
      end
      S_OBJ: begin
        bval <= VAL_W'($signed({1'b0, root}) + box_adj);
        if (obj_idx == '0) begin
          acc <= VAL_W'($signed({1'b0, root}) + box_adj);
        end
      end
      S_CMP: begin
        cnt      <= '0;
        diff_neg <= diff[VAL_W];
        drem     <= diff[VAL_W] ? 32'(-diff) : 32'(diff);
        quo      <= '0;
        if (diff <= -kext) begin
          acc <= bval;
        end
      end
      S_DIV: begin
        cnt <= cnt + 1'b1;
        if (drem2 >= {1'b0, kq}) begin
          drem <= drem2 - {1'b0, kq};
          quo  <= {quo[FRAC_BITS-2:0], 1'b1};
        end else begin
          drem <= drem2;
          quo  <= {quo[FRAC_BITS-2:0], 1'b0};
        end
      end
      S_H: begin
        hval <= diff_neg ? HALF_FX - {1'b0, quo} : HALF_FX + {1'b0, quo};
      end
      S_MULM: begin
        mval <= bval + VAL_W'(prod_m >>> FRAC_BITS);
      end
      S_MULT: begin
        tval <= (FRAC_BITS + 1)'(prod_t >> FRAC_BITS);
      end
      S_MULK: begin
        acc <= mval - $signed({1'b0, (VAL_W - 1)'(prod_k >> FRAC_BITS)});
      end
      S_DONE: begin
        if (out_free) begin
          if (acc > $signed(VAL_W'(32'sh7FFF_FFFF))) begin
            distance <= 32'sh7FFF_FFFF;
          end else if (acc < -$signed(VAL_W'(33'sh0_8000_0000))) begin
            distance <= 32'sh8000_0000;
          end else begin
            distance <= acc[31:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("table write outside idle");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished evaluation not presented");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> drem < {1'b0, kq})
    else $error("division remainder out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> obj_idx <= last_idx)
    else $error("object index beyond count");
`endif

endmodule
`default_nettype wire

### dv/sdf_scene_smooth_union_tb.sv
// ----------------------------------------------------------------------------
// sdf_scene_smooth_union_tb
// Self-checking bench for the smooth-union scene distance evaluator. Object
// entries are loaded and query points evaluated under random idling on both
// channels. Each distance word is checked against a behavioural predictor.
// ----------------------------------------------------------------------------
module sdf_scene_smooth_union_tb;
  import sdfsu_pkg::*;

  typedef struct {
    logic        fn;
    logic [3:0]  idx;
    logic        kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [30:0] ext;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [3:0] entry_index = '0;
  logic entry_kind = 1'b0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [30:0] extent = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] distance;

  sdf_scene_smooth_union dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  word_t pending_words[$];
  logic signed [31:0] expected_distances[$];
  int mismatches = 0;
  int evals_checked = 0;
  int words_sent = 0;
  bit calm = 1'b0;
  int hold_off = 0;
  bit send_pause = 1'b0;

  // Predictor state.
  logic signed [63:0] tx[16], ty[16], tz[16], te[16];
  logic tkind[16];
  int unsigned n_obj = 1;
  logic signed [63:0] k_blend = 6554;

  function automatic logic signed [63:0] fshift(logic signed [63:0] v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] len_floor(logic [63:0] a, b, c);
    logic [127:0] s, cand;
    logic [63:0] r;
    s = a * a + b * b + c * c;
    r = 0;
    for (int bitn = 33; bitn >= 0; bitn--) begin
      cand = r | (64'd1 << bitn);
      if (cand * cand <= s) r = cand[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] shape_distance(int i, logic signed [63:0] px, py, pz);
    logic signed [63:0] dx, dy, dz, qx, qy, qz, mx;
    dx = px - tx[i];
    dy = py - ty[i];
    dz = pz - tz[i];
    if (tkind[i] == KIND_SPHERE)
      return len_floor(magnitude(dx), magnitude(dy), magnitude(dz)) - te[i];
    qx = $signed(magnitude(dx)) - te[i];
    qy = $signed(magnitude(dy)) - te[i];
    qz = $signed(magnitude(dz)) - te[i];
    mx = qx > qy ? qx : qy;
    mx = mx > qz ? mx : qz;
    return len_floor(qx > 0 ? qx : 0, qy > 0 ? qy : 0, qz > 0 ? qz : 0) + (mx < 0 ? mx : 0);
  endfunction

  function automatic logic signed [63:0] blend_min(logic signed [63:0] a, b, k);
    logic signed [63:0] diff, h, q, m, t;
    logic [63:0] num;
    diff = b - a;
    if (diff >= k) return a;
    if (diff <= -k) return b;
    num = magnitude(diff) * 64'(HALF_FX);
    q = $signed(num / k);
    h = diff < 0 ? 64'(HALF_FX) - q : 64'(HALF_FX) + q;
    m = b + fshift((a - b) * h);
    t = fshift(h * (64'(ONE_FX) - h));
    return m - fshift(k * t);
  endfunction

  function automatic logic signed [31:0] scene_distance(word_t w);
    logic signed [63:0] px, py, pz, acc;
    int unsigned n;
    px = $signed(w.x);
    py = $signed(w.y);
    pz = $signed(w.z);
    n = n_obj < 1 ? 1 : (n_obj > MAX_OBJECTS ? MAX_OBJECTS : n_obj);
    acc = shape_distance(0, px, py, pz);
    for (int i = 1; i < n; i++) acc = blend_min(acc, shape_distance(i, px, py, pz), k_blend);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Driver.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) words_sent++;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !send_pause && !calm &&
                     $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 14);
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !send_pause) begin
          word_t w;
          w = pending_words.pop_front();
          if (w.fn == FUNC_WRITE) begin
            tkind[w.idx] = w.kind;
            tx[w.idx] = $signed(w.x);
            ty[w.idx] = $signed(w.y);
            tz[w.idx] = $signed(w.z);
            te[w.idx] = {33'd0, w.ext};
          end else begin
            expected_distances.push_back(scene_distance(w));
          end
          in_valid <= 1'b1;
          func <= w.fn;
          entry_index <= w.idx;
          entry_kind <= w.kind;
          coord_x <= w.x;
          coord_y <= w.y;
          coord_z <= w.z;
          extent <= w.ext;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver idling.
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_distances.size() == 0) begin
          report_mismatch("unexpected word", distance, 0);
        end else begin
          logic signed [31:0] want;
          want = expected_distances.pop_front();
          if (distance !== want) report_mismatch("distance", distance, want);
          evals_checked++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h000A0000)) - 32'sh00050000);
      default: return 32'($signed($urandom_range(0, 32'h00C80000)) - 32'sh00640000);
    endcase
  endfunction

  function automatic word_t make_write(int i, int mode);
    word_t w;
    w.fn = FUNC_WRITE;
    w.idx = 4'(i);
    w.kind = 1'($urandom_range(0, 1));
    w.x = rand_coord(mode);
    w.y = rand_coord(mode);
    w.z = rand_coord(mode);
    w.ext = mode == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h00030000));
    return w;
  endfunction

  function automatic word_t make_eval(int mode);
    word_t w;
    w = make_write(0, mode);
    w.fn = FUNC_EVAL;
    w.idx = 4'($urandom());
    w.ext = 31'($urandom());
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_distances.size() > 0)
      @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OBJ_CNT) n_obj = val[4:0];
    else k_blend = {33'd0, val};
  endtask

  initial begin
    word_t w;
    int counts[6] = '{0, 1, 3, 16, 31, 2};
    int ks[6] = '{1, 6554, 32'h7FFFFFFF, 0, 65536, 300000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes of every field, both shapes.
    for (int i = 0; i < 16; i++) pending_words.push_back(make_write(i, 1));
    w = make_write(15, 0);
    w.x = 32'h7FFFFFFF; w.y = 32'h80000000; w.z = 32'h0; w.ext = 31'h7FFFFFFF; w.kind = KIND_BOX;
    pending_words.push_back(w);
    w = make_eval(0);
    w.x = 32'h80000000; w.y = 32'h7FFFFFFF; w.z = 32'hFFFFFFFF;
    pending_words.push_back(w);
    w.x = 32'h0; w.y = 32'h0; w.z = 32'h0;
    pending_words.push_back(w);
    pending_words.push_back(make_eval(1));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_OBJ_CNT, 31'(counts[ph]));
      write_cfg(CFG_BLEND_K, 31'(ks[ph]));
      if (ph == 5) calm = 1'b1;
      for (int j = 0; j < 140; j++) begin
        int mode;
        mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
        if ($urandom_range(0, 3) == 0) pending_words.push_back(make_write($urandom_range(0, 15), mode));
        else pending_words.push_back(make_eval(mode));
      end
      if (ph == 1) begin
        hold_off <= 3000;
      end
      if (ph == 2) begin
        while (pending_words.size() > 70) @(posedge clk);
        send_pause = 1'b1;
        while (expected_distances.size() > 0) @(posedge clk);
        send_pause = 1'b0;
      end
      wait_drained();
    end

    $display("Sent %0d words and checked %0d distances over six configuration phases,",
             words_sent, evals_checked);
    $display("covering object counts 0 to 31 and blend widths from zero to the maximum.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

### filelist.f
sv/sdfsu_pkg.sv
sv/sdfsu_ram.sv
sv/sdf_scene_smooth_union.sv
dv/sdf_scene_smooth_union_tb.sv
